// ===== rtl/bcpa_pkg.sv =====
// ============================================================================
// bcpa_pkg
// Shared types and constants of the contiguous page allocator.
// ============================================================================
`default_nettype none

package bcpa_pkg;

  localparam int DEF_REGIONS   = 2;
  localparam int DEF_MAX_PAGES = 1024;
  localparam int PAGE_OFS_BITS = 12;

  // Request commands; any other code is a size query.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_NOMEM   = 3'd2;
  localparam logic [2:0] ST_NORUN   = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_REGIONS = 3'd0;
  localparam logic [2:0] REG_FIRST   = 3'd1;
  localparam logic [2:0] REG_LAST    = 3'd4;

  // Outcome of the request check.
  typedef enum logic [2:0] {
    CHK_BAD,
    CHK_ZERO,
    CHK_NOMEM,
    CHK_RANGE,
    CHK_QUERY,
    CHK_ALLOC,
    CHK_FREE
  } chk_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan_start;
    logic scan_eval;
    logic scan_miss;
    logic fill_step;
    logic commit_alloc;
    logic free_start;
    logic free_step;
    logic commit_free;
    logic clear_step;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic clr_busy;
    chk_t chk;
    logic scan_fail;
    logic hit;
    logic found;
    logic fill_last;
    logic free_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/bcpa_ctrl.sv =====
// ============================================================================
// bcpa_ctrl
// Sequencer of the allocator: clearing sweeps, check, scan, fill and free.
// ============================================================================
`default_nettype none

module bcpa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire bcpa_pkg::stat_t st,
  output bcpa_pkg::ctl_t       ctl
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_SCHK  = 9'b000001000,
    S_SRD   = 9'b000010000,
    S_SEV   = 9'b000100000,
    S_FILL  = 9'b001000000,
    S_FREE  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !st.clr_busy;

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (st.clr_busy) begin
          state_next = S_CLEAR;
        end else if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CLEAR: begin
        if (st.clr_busy) begin
          ctl.clear_step = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        ctl.check = 1'b1;
        case (st.chk)
          bcpa_pkg::CHK_ALLOC: begin
            ctl.scan_start = 1'b1;
            state_next = S_SCHK;
          end
          bcpa_pkg::CHK_FREE: begin
            ctl.free_start = 1'b1;
            state_next = S_FREE;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_SCHK: begin
        if (st.scan_fail) begin
          ctl.scan_miss = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_SRD;
        end
      end
      S_SRD: state_next = S_SEV;
      S_SEV: begin
        ctl.scan_eval = 1'b1;
        state_next = (!st.hit && st.found) ? S_FILL : S_SCHK;
      end
      S_FILL: begin
        ctl.fill_step = 1'b1;
        if (st.fill_last) begin
          ctl.commit_alloc = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FREE: begin
        ctl.free_step = 1'b1;
        if (st.free_last) begin
          ctl.commit_free = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          ctl.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcpa_dp.sv =====
// ============================================================================
// bcpa_dp
// Datapath: region registers, byte counters, page bitmap and search logic.
// ============================================================================
`default_nettype none

module bcpa_dp #(
  parameter int REGIONS   = bcpa_pkg::DEF_REGIONS,
  parameter int MAX_PAGES = bcpa_pkg::DEF_MAX_PAGES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [35:0]     cfg_data,
  input  wire logic [1:0]      command,
  input  wire logic [1:0]      region_index,
  input  wire logic [31:0]     request_bytes,
  input  wire logic [31:0]     align_bytes,
  input  wire logic [47:0]     free_address,
  input  wire bcpa_pkg::ctl_t  ctl,
  output bcpa_pkg::stat_t      st,
  output logic [2:0]           status,
  output logic [47:0]          alloc_address,
  output logic [22:0]          free_bytes,
  output logic [22:0]          used_bytes,
  output logic [22:0]          total_bytes
);

  localparam int PW   = $clog2(MAX_PAGES + 1);
  localparam int IW   = PW + 1;
  localparam int RW   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int AW   = $clog2(REGIONS * MAX_PAGES);
  localparam int CW   = PW + bcpa_pkg::PAGE_OFS_BITS;
  localparam int CLRW = $clog2(MAX_PAGES);
  localparam logic [CW-1:0] LIM = CW'(MAX_PAGES) << bcpa_pkg::PAGE_OFS_BITS;

  function automatic logic [CW-1:0] setup_bytes(input logic [10:0] pg);
    return (32'(pg) <= MAX_PAGES) ? CW'({pg, 12'h000}) : '0;
  endfunction

  function automatic logic [AW-1:0] maddr(input logic [RW-1:0] r, input logic [IW-1:0] pg);
    return AW'(r) * AW'(MAX_PAGES) + AW'(pg);
  endfunction

  // Region registers and counters.
  logic [1:0]      rin_use;
  logic [35:0]     base_page [REGIONS];
  logic [10:0]     pages     [REGIONS];
  logic [CW-1:0]   free_cnt  [REGIONS];
  logic [CW-1:0]   used_cnt  [REGIONS];
  logic [REGIONS-1:0] clr_pend;
  logic [CLRW-1:0] clr_page;
  logic [RW-1:0]   clr_reg;

  // Latched request.
  logic [1:0]  q_cmd;
  logic [1:0]  q_ridx;
  logic [31:0] q_size;
  logic [31:0] q_align;
  logic [47:0] q_addr;

  // Working registers.
  logic [IW-1:0] s, p, mb, ph;
  logic [2:0]    res_status;
  logic [47:0]   res_addr;
  logic          res_ok;
  logic          rd;

  logic mem [REGIONS*MAX_PAGES];

  // Configuration decode.
  logic [2:0]    cfg_r;
  logic          cfg_hit;
  logic [RW-1:0] cfg_ri;
  logic [10:0]   setup_pg;

  assign cfg_r   = (cfg_index - bcpa_pkg::REG_FIRST) >> 1;
  assign cfg_hit = cfg_write && cfg_index >= bcpa_pkg::REG_FIRST &&
                   cfg_index <= bcpa_pkg::REG_LAST && 32'(cfg_r) < REGIONS;
  assign cfg_ri  = RW'(cfg_r);
  assign setup_pg = !cfg_index[0] ? cfg_data[10:0] : pages[cfg_ri];

  always_comb begin
    clr_reg = '0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (clr_pend[i]) clr_reg = RW'(i);
    end
  end

  // Request decode.
  logic          idx_ok, ok;
  logic [RW-1:0] rg;
  logic [10:0]   npg;
  logic [IW-1:0] npg_i;
  logic [47:0]   base_b, off;
  logic [22:0]   total_b;
  logic [20:0]   size_pg, align_pg, ap_raw;
  logic [IW-1:0] want_i, ap_i, start_i, fend;
  logic [IW:0]   fsum;
  logic          range_bad;
  bcpa_pkg::chk_t chk;

  assign idx_ok  = (q_ridx < rin_use) && (32'(q_ridx) < REGIONS);
  assign rg      = idx_ok ? RW'(q_ridx) : '0;
  assign npg     = pages[rg];
  assign npg_i   = IW'(npg);
  assign ok      = idx_ok && npg != 11'd0 && 32'(npg) <= MAX_PAGES;
  assign base_b  = {base_page[rg], 12'h000};
  assign total_b = {npg, 12'h000};
  assign size_pg  = 21'((33'(q_size) + 33'd4095) >> bcpa_pkg::PAGE_OFS_BITS);
  assign align_pg = 21'((33'(q_align) + 33'd4095) >> bcpa_pkg::PAGE_OFS_BITS);
  assign ap_raw   = (q_align > 32'd4096) ? align_pg : 21'd1;
  // Alignments beyond the region all behave alike: any blocked page ends the search.
  assign ap_i     = (32'(ap_raw) > MAX_PAGES) ? IW'(MAX_PAGES + 1) : IW'(ap_raw);
  assign want_i   = IW'(size_pg);
  assign range_bad = (q_addr < base_b) ||
                     ((49'(q_addr) + 49'(q_size)) > (49'(base_b) + 49'(total_b)));
  assign off     = q_addr - base_b;
  assign start_i = IW'(off >> bcpa_pkg::PAGE_OFS_BITS);
  assign fsum    = (IW+1)'(start_i) + (IW+1)'(want_i);
  assign fend    = (fsum > (IW+1)'(npg_i)) ? npg_i : IW'(fsum);

  always_comb begin
    if (!ok) begin
      chk = bcpa_pkg::CHK_BAD;
    end else if ((q_cmd == bcpa_pkg::CMD_ALLOC || q_cmd == bcpa_pkg::CMD_FREE) &&
                 q_size == 32'd0) begin
      chk = bcpa_pkg::CHK_ZERO;
    end else if (q_cmd == bcpa_pkg::CMD_ALLOC) begin
      chk = (q_size > 32'(free_cnt[rg])) ? bcpa_pkg::CHK_NOMEM : bcpa_pkg::CHK_ALLOC;
    end else if (q_cmd == bcpa_pkg::CMD_FREE) begin
      chk = range_bad ? bcpa_pkg::CHK_RANGE : bcpa_pkg::CHK_FREE;
    end else begin
      chk = bcpa_pkg::CHK_QUERY;
    end
  end

  logic [IW-1:0] s_jump;
  logic [32:0]   free_sum;
  assign s_jump   = mb + ap_i;
  assign free_sum = 33'(free_cnt[rg]) + 33'(q_size);

  always_comb begin
    st.clr_busy  = |clr_pend;
    st.chk       = chk;
    st.scan_fail = ((IW+1)'(s) + (IW+1)'(want_i)) > (IW+1)'(npg_i);
    st.hit       = rd;
    st.found     = ((IW+1)'(p) + (IW+1)'(1) - (IW+1)'(s)) == (IW+1)'(want_i);
    st.fill_last = ((IW+1)'(p) + (IW+1)'(1)) == ((IW+1)'(s) + (IW+1)'(want_i));
    st.free_last = ((IW+1)'(p) + (IW+1)'(1)) >= (IW+1)'(fend);
  end

  // Bitmap: one write port, one registered read port.
  logic          mem_we, mem_wd;
  logic [AW-1:0] waddr, raddr;
  assign mem_we = ctl.clear_step || ctl.fill_step || ctl.free_step;
  assign mem_wd = ctl.fill_step;
  assign waddr  = ctl.clear_step ? maddr(clr_reg, IW'(clr_page)) : maddr(rg, p);
  assign raddr  = maddr(rg, p);

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= mem_wd;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rin_use  <= '0;
      clr_pend <= '1;
      clr_page <= '0;
      for (int i = 0; i < REGIONS; i++) begin
        base_page[i] <= '0;
        pages[i]     <= '0;
        free_cnt[i]  <= '0;
        used_cnt[i]  <= '0;
      end
    end else begin
      if (ctl.clear_step) begin
        if (clr_page == CLRW'(MAX_PAGES - 1)) begin
          clr_page <= '0;
          clr_pend[clr_reg] <= 1'b0;
        end else begin
          clr_page <= clr_page + 1'b1;
        end
      end
      if (ctl.commit_alloc) begin
        free_cnt[rg] <= free_cnt[rg] - CW'(q_size);
        used_cnt[rg] <= used_cnt[rg] + CW'(q_size);
      end
      if (ctl.commit_free) begin
        free_cnt[rg] <= (free_sum > 33'(LIM)) ? LIM : CW'(free_sum);
        used_cnt[rg] <= (32'(used_cnt[rg]) > q_size) ? used_cnt[rg] - CW'(q_size) : '0;
      end
      // Setting a region up again frees all its pages.
      if (cfg_write && cfg_index == bcpa_pkg::REG_REGIONS) rin_use <= cfg_data[1:0];
      if (cfg_hit) begin
        if (cfg_index[0]) base_page[cfg_ri] <= cfg_data;
        else pages[cfg_ri] <= cfg_data[10:0];
        free_cnt[cfg_ri] <= setup_bytes(setup_pg);
        used_cnt[cfg_ri] <= '0;
        clr_pend[cfg_ri] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_cmd   <= command;
      q_ridx  <= region_index;
      q_size  <= request_bytes;
      q_align <= align_bytes;
      q_addr  <= free_address;
    end
    if (ctl.check) begin
      res_ok   <= ok;
      res_addr <= '0;
      case (chk)
        bcpa_pkg::CHK_BAD, bcpa_pkg::CHK_ZERO: res_status <= bcpa_pkg::ST_BAD;
        bcpa_pkg::CHK_NOMEM: res_status <= bcpa_pkg::ST_NOMEM;
        bcpa_pkg::CHK_RANGE: res_status <= bcpa_pkg::ST_BADADDR;
        default:             res_status <= bcpa_pkg::ST_OK;
      endcase
    end
    if (ctl.scan_start) begin
      s  <= '0;
      p  <= '0;
      mb <= '0;
      ph <= '0;
    end
    if (ctl.scan_miss) res_status <= bcpa_pkg::ST_NORUN;
    if (ctl.scan_eval) begin
      if (rd) begin
        // Restart at the next aligned page past the blocked one.
        s  <= s_jump;
        p  <= s_jump;
        mb <= s_jump;
        ph <= '0;
      end else if (st.found) begin
        p <= s;
      end else begin
        p <= p + 1'b1;
        if (ph + 1'b1 == ap_i) begin
          ph <= '0;
          mb <= p + 1'b1;
        end else begin
          ph <= ph + 1'b1;
        end
      end
    end
    if (ctl.free_start) p <= start_i;
    if (ctl.fill_step || ctl.free_step) p <= p + 1'b1;
    if (ctl.commit_alloc) res_addr <= base_b + (48'(s) << bcpa_pkg::PAGE_OFS_BITS);
    if (ctl.emit) begin
      status        <= res_status;
      alloc_address <= res_addr;
      free_bytes    <= res_ok ? 23'(free_cnt[rg]) : '0;
      used_bytes    <= res_ok ? 23'(used_cnt[rg]) : '0;
      total_bytes   <= res_ok ? total_b : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_contiguous_page_allocator_top.sv =====
// ============================================================================
// bitmap_contiguous_page_allocator_top
// First-fit aligned contiguous page allocator over per-region page bitmaps.
// ============================================================================
//
//  Channel  Handshake               Payload
//  in       in_valid / in_ready     command, region_index, request_bytes,
//                                   align_bytes, free_address
//  out      out_valid / out_ready   status, alloc_address, free_bytes,
//                                   used_bytes, total_bytes
//  cfg      cfg_write               cfg_index, cfg_data
//
//  One request at a time. A query or rejected request is loaded, checked and
//  finished; an allocate probes pages in scan check, read and evaluate, then
//  marks the run's pages on success or finishes on a miss; a free clears its
//  pages one at a time. After reset the bitmap is swept, one page a cycle,
//  over REGIONS*MAX_PAGES pages; each set-up sweeps its own region. A result
//  waits in the output register while the next request is accepted.
`default_nettype none

module bitmap_contiguous_page_allocator_top #(
  parameter int REGIONS   = bcpa_pkg::DEF_REGIONS,
  parameter int MAX_PAGES = bcpa_pkg::DEF_MAX_PAGES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [35:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [1:0]  region_index,
  input  wire logic [31:0] request_bytes,
  input  wire logic [31:0] align_bytes,
  input  wire logic [47:0] free_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [47:0]      alloc_address,
  output logic [22:0]      free_bytes,
  output logic [22:0]      used_bytes,
  output logic [22:0]      total_bytes
);

  bcpa_pkg::ctl_t  ctl;
  bcpa_pkg::stat_t st;

  bcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  bcpa_dp #(
    .REGIONS   (REGIONS),
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .region_index  (region_index),
    .request_bytes (request_bytes),
    .align_bytes   (align_bytes),
    .free_address  (free_address),
    .ctl           (ctl),
    .st            (st),
    .status        (status),
    .alloc_address (alloc_address),
    .free_bytes    (free_bytes),
    .used_bytes    (used_bytes),
    .total_bytes   (total_bytes)
  );

endmodule

`default_nettype wire

// ===== rtl/bcpa_checker.sv =====
// ============================================================================
// bcpa_checker
// Port-level checks of the allocator, attached to the top level.
// ============================================================================
`default_nettype none

module bcpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [47:0] alloc_address
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_addr_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bcpa_pkg::ST_OK |-> alloc_address == 48'd0)
    else $error("address reported on a failed request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= bcpa_pkg::ST_BADADDR)
    else $error("undefined status code");

endmodule

bind bitmap_contiguous_page_allocator_top bcpa_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .alloc_address (alloc_address)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ============================================================================
// Contiguous page allocator testbench
// Drives allocate, free and query requests through the valid/ready channels,
// predicts each result from a private copy of the page bitmaps and byte
// counts, and checks every result in order across several region layouts.
// ============================================================================
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [2:0] REG_BASE0  = bcpa_pkg::REG_FIRST;
  localparam logic [2:0] REG_PAGES0 = bcpa_pkg::REG_FIRST + 3'd1;
  localparam logic [2:0] REG_BASE1  = bcpa_pkg::REG_FIRST + 3'd2;
  localparam logic [2:0] REG_PAGES1 = bcpa_pkg::REG_LAST;
  localparam logic [2:0] REG_UNUSED = bcpa_pkg::REG_LAST + 3'd1;
  localparam longint unsigned PAGE_CAP = 64'd1024 << 12;
  localparam longint CYCLE_LIMIT = 30000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  region;
    logic [31:0] nbytes;
    logic [31:0] align;
    logic [47:0] addr;
  } req_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [47:0] addr;
    logic [22:0] fr;
    logic [22:0] us;
    logic [22:0] tot;
  } rsp_t;

  typedef struct {
    req_t q;
    bit   typed;
    rsp_t res;
  } row_t;

  typedef struct {
    int          region;
    logic [47:0] addr;
    logic [31:0] nbytes;
  } block_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write = 0;
  logic [2:0]  cfg_index = '0;
  logic [35:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [1:0]  region_index = '0;
  logic [31:0] request_bytes = '0;
  logic [31:0] align_bytes = '0;
  logic [47:0] free_address = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  status;
  logic [47:0] alloc_address;
  logic [22:0] free_bytes;
  logic [22:0] used_bytes;
  logic [22:0] total_bytes;

  bitmap_contiguous_page_allocator_top dut (.*);

  always #1 clk = ~clk;

  // Private copy of the allocator state.
  bit              occupied[2][1024];
  longint unsigned free_cnt[2], used_cnt[2], base_pg[2], npg[2];
  int unsigned     inuse;

  rsp_t   pending[$];
  block_t live[$];
  int     errors = 0;
  bit     calm = 0;
  int     hold_asks = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  longint cycles = 0;

  function automatic void setup_region(int r);
    for (int p = 0; p < 1024; p++) occupied[r][p] = 0;
    free_cnt[r] = (npg[r] <= 1024) ? (npg[r] << 12) : 0;
    used_cnt[r] = 0;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [35:0] val);
    int r;
    if (idx == bcpa_pkg::REG_REGIONS) begin
      inuse = 32'(val[1:0]);
    end else if (idx <= bcpa_pkg::REG_LAST) begin
      r = (idx - 1) >> 1;
      if (((idx - 1) & 1) == 0) base_pg[r] = 64'(val);
      else npg[r] = 64'(val[10:0]);
      setup_region(r);
    end
  endfunction

  function automatic rsp_t allocator_outcome(req_t q);
    rsp_t o;
    longint unsigned n, base, total, want, ap, s, blocked, start, cnt, size, addr, i;
    int r;
    bit hit;
    o = '0;
    r = q.region;
    if (r >= inuse || r >= 2) begin
      o.st = bcpa_pkg::ST_BAD;
      return o;
    end
    if (npg[r] == 0 || npg[r] > 1024) begin
      o.st = bcpa_pkg::ST_BAD;
      return o;
    end
    n = npg[r];
    base = base_pg[r] << 12;
    total = n << 12;
    size = q.nbytes;
    addr = q.addr;
    o.st = bcpa_pkg::ST_OK;
    if (q.cmd == bcpa_pkg::CMD_ALLOC || q.cmd == bcpa_pkg::CMD_FREE) begin
      if (size == 0) begin
        o.st = bcpa_pkg::ST_BAD;
      end else if (q.cmd == bcpa_pkg::CMD_ALLOC) begin
        if (size > free_cnt[r]) begin
          o.st = bcpa_pkg::ST_NOMEM;
        end else begin
          want = (size + 4095) >> 12;
          ap = (q.align > 32'd4096) ? ((64'(q.align) + 4095) >> 12) : 1;
          s = 0;
          hit = 0;
          // First fit: restart past the blocking page on the next aligned start.
          while (!hit && s + want <= n) begin
            blocked = n;
            for (i = 0; i < want; i++) begin
              if (occupied[r][s + i]) begin
                blocked = s + i;
                break;
              end
            end
            if (blocked == n) hit = 1;
            else s = (blocked / ap + 1) * ap;
          end
          if (!hit) begin
            o.st = bcpa_pkg::ST_NORUN;
          end else begin
            for (i = 0; i < want; i++) occupied[r][s + i] = 1;
            o.addr = 48'(base + (s << 12));
            free_cnt[r] -= size;
            used_cnt[r] += size;
          end
        end
      end else begin
        if (addr < base || addr + size > base + total) begin
          o.st = bcpa_pkg::ST_BADADDR;
        end else begin
          start = (addr - base) >> 12;
          cnt = (size + 4095) >> 12;
          for (i = 0; i < cnt; i++)
            if (start + i < n) occupied[r][start + i] = 0;
          free_cnt[r] += size;
          if (free_cnt[r] > PAGE_CAP) free_cnt[r] = PAGE_CAP;
          used_cnt[r] = (used_cnt[r] > size) ? used_cnt[r] - size : 0;
        end
      end
    end
    o.fr = 23'(free_cnt[r]);
    o.us = 23'(used_cnt[r]);
    o.tot = 23'(total);
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [35:0] val);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    apply_register(idx, val);
    // A region write starts a bitmap sweep of that region.
    if (idx != bcpa_pkg::REG_REGIONS && idx <= bcpa_pkg::REG_LAST)
      repeat (1100) @(negedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_layout(int unsigned n_in, logic [35:0] b0, logic [10:0] p0,
                            logic [35:0] b1, logic [10:0] p1);
    drain();
    live.delete();
    write_reg(bcpa_pkg::REG_REGIONS, 36'(n_in));
    write_reg(REG_BASE0, b0);
    write_reg(REG_PAGES0, 36'(p0));
    write_reg(REG_BASE1, b1);
    write_reg(REG_PAGES1, 36'(p1));
  endtask

  task automatic send_request(req_t q, bit typed, rsp_t typed_res);
    rsp_t want;
    block_t b;
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    command <= q.cmd;
    region_index <= q.region;
    request_bytes <= q.nbytes;
    align_bytes <= q.align;
    free_address <= q.addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = allocator_outcome(q);
    if (q.cmd == bcpa_pkg::CMD_ALLOC && want.st == bcpa_pkg::ST_OK) begin
      b.region = q.region;
      b.addr = want.addr;
      b.nbytes = q.nbytes;
      live.push_back(b);
    end
    pending.push_back(typed ? typed_res : want);
    @(negedge clk);
  endtask

  function automatic req_t random_request();
    req_t q;
    longint unsigned span;
    int k, r;
    int p;
    q.cmd = 2'($urandom_range(3));
    q.region = 2'($urandom_range(3));
    q.nbytes = $urandom;
    q.align = $urandom;
    q.addr = 48'({$urandom, $urandom});
    p = $urandom_range(99);
    r = $urandom_range(1);
    if (p < 10 || npg[r] == 0 || npg[r] > 1024) return q;
    q.region = 2'(r);
    span = npg[r] << 12;
    if (p < 50) begin
      q.cmd = bcpa_pkg::CMD_ALLOC;
      q.nbytes = ($urandom_range(9) == 0) ? $urandom_range(1, 32'(span))
                                           : $urandom_range(1, 32'(span / 4 + 1));
      case ($urandom_range(3))
        0: q.align = $urandom_range(0, 4096);
        1: q.align = 32'd4096 << $urandom_range(0, 3);
        2: q.align = $urandom_range(4097, 40000);
        default: q.align = $urandom;
      endcase
    end else if (p < 80) begin
      q.cmd = bcpa_pkg::CMD_FREE;
      if (live.size() != 0 && $urandom_range(4) != 0) begin
        k = $urandom_range(live.size() - 1);
        q.region = 2'(live[k].region);
        q.addr = live[k].addr;
        q.nbytes = live[k].nbytes;
        live.delete(k);
      end else begin
        q.addr = 48'((base_pg[r] << 12) + 64'($urandom_range(0, 32'(span))));
        q.nbytes = $urandom_range(0, 3 * 4096);
      end
    end else begin
      q.cmd = $urandom_range(1) ? CMD_QUERY : CMD_SPARE;
    end
    return q;
  endfunction

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) send_request(random_request(), 0, '0);
  endtask

  function automatic rsp_t sizes(logic [2:0] st, int fr, int us, int tot);
    rsp_t o;
    o.st = st;
    o.addr = '0;
    o.fr = 23'(fr);
    o.us = 23'(us);
    o.tot = 23'(tot);
    return o;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, status %0d", $realtime, status);
      end else begin
        e = pending.pop_front();
        check_field("status", 48'(e.st), 48'(status));
        check_field("alloc_address", e.addr, alloc_address);
        check_field("free_bytes", 48'(e.fr), 48'(free_bytes));
        check_field("used_bytes", 48'(e.us), 48'(used_bytes));
        check_field("total_bytes", 48'(e.tot), 48'(total_bytes));
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  row_t dir[$];

  initial begin
    row_t w;
    localparam logic [47:0] B0 = 48'h100000;
    localparam logic [47:0] B1 = 48'hFFFFFFFFF000;
    for (int p = 0; p < 2; p++) begin
      base_pg[p] = 0;
      npg[p] = 0;
      setup_region(p);
    end
    inuse = 0;

    // Directed rows; the first runs straight after reset with no region set up.
    w.typed = 1; w.q = '{CMD_QUERY, 2'd0, 32'd0, 32'd0, 48'd0};
    w.res = sizes(bcpa_pkg::ST_BAD, 0, 0, 0); dir.push_back(w);
    w.q = '{CMD_QUERY, 2'd0, 32'd0, 32'd0, 48'd0};
    w.res = sizes(bcpa_pkg::ST_OK, 65536, 0, 65536); dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'd0, 32'd0, 48'd0};
    w.res = sizes(bcpa_pkg::ST_BAD, 65536, 0, 65536); dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_FREE, 2'd0, 32'd0, 32'd0, B0};
    w.res = sizes(bcpa_pkg::ST_BAD, 65536, 0, 65536); dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd2, 32'd4096, 32'd0, 48'd0};
    w.res = sizes(bcpa_pkg::ST_BAD, 0, 0, 0); dir.push_back(w);
    w.q = '{CMD_SPARE, 2'd3, 32'd1, 32'd0, 48'd0};
    w.res = sizes(bcpa_pkg::ST_BAD, 0, 0, 0); dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 48'd0};
    w.res = sizes(bcpa_pkg::ST_NOMEM, 65536, 0, 65536); dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_FREE, 2'd0, 32'd4096, 32'd0, 48'd0};
    w.res = sizes(bcpa_pkg::ST_BADADDR, 65536, 0, 65536); dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_FREE, 2'd0, 32'd1, 32'd0, 48'hFFFFFFFFFFFF};
    w.res = sizes(bcpa_pkg::ST_BADADDR, 65536, 0, 65536); dir.push_back(w);
    w.typed = 0;
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'd1, 32'd0, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'd4097, 32'd8192, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'd4096, 32'hFFFFFFFF, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'd4096, 32'd4097, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd1, 32'd16384, 32'd0, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd1, 32'd1, 32'd0, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_FREE, 2'd1, 32'd16384, 32'd0, B1}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_FREE, 2'd1, 32'd16384, 32'd0, B1}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'd65536, 32'd4096, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_FREE, 2'd0, 32'd65536, 32'd0, B0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_FREE, 2'd0, 32'd1, 32'd0, B0 + 48'd65535}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'd65536, 32'd0, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_ALLOC, 2'd0, 32'd1, 32'd0, 48'd0}; dir.push_back(w);
    w.q = '{bcpa_pkg::CMD_FREE, 2'd0, 32'd65537, 32'd0, B0}; dir.push_back(w);
    w.q = '{CMD_QUERY, 2'd1, 32'd0, 32'd0, 48'd0}; dir.push_back(w);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // The bitmap is swept after reset before it serves requests.
    repeat (2200) @(negedge clk);

    foreach (dir[i]) begin
      if (i == 1) begin
        drain();
        // Indexes past the last register have no effect.
        write_reg(REG_UNUSED, 36'hFFFFFFFFF);
        write_reg(3'd7, 36'h5A5A5A5A5);
        set_layout(2, 36'h100, 11'd16, 36'hFFFFFFFFF, 11'd4);
      end
      send_request(dir[i].q, dir[i].typed, dir[i].res);
    end

    set_layout(2, 36'({$urandom, $urandom}), 11'd32, 36'({$urandom, $urandom}), 11'd8);
    random_phase(200);
    hold_asks++;
    random_phase(200);
    set_layout(1, 36'd0, 11'd64, 36'd0, 11'd0);
    random_phase(150);
    drain();
    random_phase(150);
    set_layout(3, 36'({$urandom, $urandom}), 11'd1, 36'hFFFFFFFFF, 11'h7FF);
    random_phase(150);
    set_layout(2, 36'hFFFFFFFFF, 11'd1024, 36'({$urandom, $urandom}), 11'd16);
    random_phase(100);
    set_layout(0, 36'd0, 11'd8, 36'd0, 11'd8);
    random_phase(50);
    set_layout(2, 36'({$urandom, $urandom}), 11'd48, 36'({$urandom, $urandom}), 11'd24);
    calm = 1;
    random_phase(120);
    calm = 0;
    random_phase(130);

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
